// ===== hdl/tcpwm_pkg.sv =====
// Shared types, constants and register map of the two-channel PWM time base.
package tcpwm_pkg;

  // Width of the counter, the period and the compare registers.
  localparam int unsigned CountBits = 16;

  typedef logic [CountBits-1:0] count_t;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Register byte offsets.
  localparam logic [4:0] ADDR_TBCTL   = 5'h00;
  localparam logic [4:0] ADDR_TBCTR   = 5'h08;
  localparam logic [4:0] ADDR_TBPRD   = 5'h0A;
  localparam logic [4:0] ADDR_CMPCTL  = 5'h0E;
  localparam logic [4:0] ADDR_CMPA    = 5'h12;
  localparam logic [4:0] ADDR_CMPB    = 5'h14;
  localparam logic [4:0] ADDR_AQCTLA  = 5'h16;
  localparam logic [4:0] ADDR_AQCTLB  = 5'h18;
  localparam logic [4:0] ADDR_AQCSFRC = 5'h1C;

  // Counter mode field value that counts up; every other value freezes.
  localparam logic [1:0] MODE_UP    = 2'd0;
  localparam logic [15:0] TBCTL_RST = 16'h0003;

  // Bit positions of the immediate-load flags in CMPCTL.
  localparam int unsigned ImmedABit = 4;
  localparam int unsigned ImmedBBit = 6;

  // Action codes of the action qualifier.
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_SET    = 2'd2;
  localparam logic [1:0] ACT_TOGGLE = 2'd3;

  // Software force codes for one output.
  localparam logic [1:0] FRC_LOW  = 2'd1;
  localparam logic [1:0] FRC_HIGH = 2'd2;

  // Counter events seen by the action qualifiers on one tick.
  typedef struct packed {
    logic zro;
    logic prd;
    logic cau;
    logic cbu;
  } evt_t;

endpackage

// ===== hdl/tcpwm_aq.sv =====
// Action qualifier and software force for one PWM output.
module tcpwm_aq (
  input  logic                 level_i,
  input  logic [15:0]          aqctl_i,
  input  tcpwm_pkg::evt_t      evt_i,
  input  logic [1:0]           force_i,
  output logic                 level_o
);

  logic [1:0] act;
  logic       qual;

  // The highest-priority event with a nonzero action selects the action.
  always_comb begin
    act = tcpwm_pkg::ACT_NONE;
    if (evt_i.cbu && aqctl_i[9:8] != tcpwm_pkg::ACT_NONE) begin
      act = aqctl_i[9:8];
    end else if (evt_i.cau && aqctl_i[5:4] != tcpwm_pkg::ACT_NONE) begin
      act = aqctl_i[5:4];
    end else if (evt_i.zro && aqctl_i[1:0] != tcpwm_pkg::ACT_NONE) begin
      act = aqctl_i[1:0];
    end else if (evt_i.prd && aqctl_i[3:2] != tcpwm_pkg::ACT_NONE) begin
      act = aqctl_i[3:2];
    end
  end

  always_comb begin
    case (act)
      tcpwm_pkg::ACT_CLEAR:  qual = 1'b0;
      tcpwm_pkg::ACT_SET:    qual = 1'b1;
      tcpwm_pkg::ACT_TOGGLE: qual = ~level_i;
      default:               qual = level_i;
    endcase
  end

  // A force code of low or high overrides the qualified level.
  always_comb begin
    case (force_i)
      tcpwm_pkg::FRC_LOW:  level_o = 1'b0;
      tcpwm_pkg::FRC_HIGH: level_o = 1'b1;
      default:             level_o = qual;
    endcase
  end

endmodule

// ===== hdl/tcpwm_core.sv =====
// Register file, time-base counter and compare logic of the PWM unit.
module tcpwm_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [1:0]  command_i,
  input  logic [4:0]  reg_addr_i,
  input  logic [15:0] write_data_i,
  output logic [15:0] read_data_o,
  output logic        out_a_o,
  output logic        out_b_o
);

  tcpwm_pkg::count_t cnt_q, cnt_d;
  tcpwm_pkg::count_t prd_q, prd_d;
  tcpwm_pkg::count_t cmpa_sh_q, cmpa_sh_d, cmpa_act_q, cmpa_act_d;
  tcpwm_pkg::count_t cmpb_sh_q, cmpb_sh_d, cmpb_act_q, cmpb_act_d;
  logic [15:0] tbctl_q, tbctl_d;
  logic [6:0]  cmpctl_q, cmpctl_d;
  logic [15:0] aqa_q, aqa_d;
  logic [15:0] aqb_q, aqb_d;
  logic [3:0]  frc_q, frc_d;
  logic        lvl_a_q, lvl_b_q;
  logic        lvl_a_d, lvl_b_d;

  tcpwm_pkg::cmd_e   cmd;
  tcpwm_pkg::evt_t   evt;
  tcpwm_pkg::count_t cnt_next;
  tcpwm_pkg::count_t cmpa_eff, cmpb_eff;
  tcpwm_pkg::count_t wr_cnt;
  logic              counting;
  logic              is_wr;

  assign cmd      = tcpwm_pkg::cmd_e'(command_i);
  assign counting = (cmd == tcpwm_pkg::CMD_TICK) && (tbctl_q[1:0] == tcpwm_pkg::MODE_UP);
  assign is_wr    = (cmd == tcpwm_pkg::CMD_WRITE);
  assign wr_cnt   = tcpwm_pkg::CountBits'(write_data_i);

  // The counter wraps once it is at or above the period.
  assign cnt_next = (cnt_q >= prd_q) ? '0 : cnt_q + tcpwm_pkg::CountBits'(1);

  // Shadowed compares load as the counter arrives at zero; events see the new values.
  always_comb begin
    cmpa_eff = cmpa_act_q;
    cmpb_eff = cmpb_act_q;
    if (cnt_next == '0) begin
      if (!cmpctl_q[tcpwm_pkg::ImmedABit]) cmpa_eff = cmpa_sh_q;
      if (!cmpctl_q[tcpwm_pkg::ImmedBBit]) cmpb_eff = cmpb_sh_q;
    end
  end

  always_comb begin
    evt.zro = counting && (cnt_next == '0);
    evt.prd = counting && (cnt_next == prd_q);
    evt.cau = counting && (cnt_next == cmpa_eff);
    evt.cbu = counting && (cnt_next == cmpb_eff);
  end

  // Next state of the register file.
  always_comb begin
    cnt_d      = cnt_q;
    prd_d      = prd_q;
    tbctl_d    = tbctl_q;
    cmpctl_d   = cmpctl_q;
    cmpa_sh_d  = cmpa_sh_q;
    cmpa_act_d = cmpa_act_q;
    cmpb_sh_d  = cmpb_sh_q;
    cmpb_act_d = cmpb_act_q;
    aqa_d      = aqa_q;
    aqb_d      = aqb_q;
    frc_d      = frc_q;
    if (counting) begin
      cnt_d      = cnt_next;
      cmpa_act_d = cmpa_eff;
      cmpb_act_d = cmpb_eff;
    end else if (is_wr) begin
      case (reg_addr_i)
        tcpwm_pkg::ADDR_TBCTL:  tbctl_d  = write_data_i;
        tcpwm_pkg::ADDR_TBCTR:  cnt_d    = wr_cnt;
        tcpwm_pkg::ADDR_TBPRD:  prd_d    = wr_cnt;
        tcpwm_pkg::ADDR_CMPCTL: cmpctl_d = write_data_i[6:0];
        tcpwm_pkg::ADDR_CMPA: begin
          cmpa_sh_d = wr_cnt;
          if (cmpctl_q[tcpwm_pkg::ImmedABit]) cmpa_act_d = wr_cnt;
        end
        tcpwm_pkg::ADDR_CMPB: begin
          cmpb_sh_d = wr_cnt;
          if (cmpctl_q[tcpwm_pkg::ImmedBBit]) cmpb_act_d = wr_cnt;
        end
        tcpwm_pkg::ADDR_AQCTLA:  aqa_d = write_data_i;
        tcpwm_pkg::ADDR_AQCTLB:  aqb_d = write_data_i;
        tcpwm_pkg::ADDR_AQCSFRC: frc_d = write_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Read mux; compares return their shadow values.
  always_comb begin
    read_data_o = '0;
    if (cmd == tcpwm_pkg::CMD_READ) begin
      case (reg_addr_i)
        tcpwm_pkg::ADDR_TBCTL:   read_data_o = tbctl_q;
        tcpwm_pkg::ADDR_TBCTR:   read_data_o = 16'(cnt_q);
        tcpwm_pkg::ADDR_TBPRD:   read_data_o = 16'(prd_q);
        tcpwm_pkg::ADDR_CMPCTL:  read_data_o = 16'(cmpctl_q);
        tcpwm_pkg::ADDR_CMPA:    read_data_o = 16'(cmpa_sh_q);
        tcpwm_pkg::ADDR_CMPB:    read_data_o = 16'(cmpb_sh_q);
        tcpwm_pkg::ADDR_AQCTLA:  read_data_o = aqa_q;
        tcpwm_pkg::ADDR_AQCTLB:  read_data_o = aqb_q;
        tcpwm_pkg::ADDR_AQCSFRC: read_data_o = 16'(frc_q);
        default:                 read_data_o = '0;
      endcase
    end
  end

  // The force register in effect is the one after this word's write.
  tcpwm_aq u_aq_a (
    .level_i (lvl_a_q),
    .aqctl_i (aqa_q),
    .evt_i   (evt),
    .force_i (frc_d[1:0]),
    .level_o (lvl_a_d)
  );

  tcpwm_aq u_aq_b (
    .level_i (lvl_b_q),
    .aqctl_i (aqb_q),
    .evt_i   (evt),
    .force_i (frc_d[3:2]),
    .level_o (lvl_b_d)
  );

  assign out_a_o = lvl_a_d;
  assign out_b_o = lvl_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      prd_q      <= '0;
      tbctl_q    <= tcpwm_pkg::TBCTL_RST;
      cmpctl_q   <= '0;
      cmpa_sh_q  <= '0;
      cmpa_act_q <= '0;
      cmpb_sh_q  <= '0;
      cmpb_act_q <= '0;
      aqa_q      <= '0;
      aqb_q      <= '0;
      frc_q      <= '0;
      lvl_a_q    <= 1'b0;
      lvl_b_q    <= 1'b0;
    end else if (step_i) begin
      cnt_q      <= cnt_d;
      prd_q      <= prd_d;
      tbctl_q    <= tbctl_d;
      cmpctl_q   <= cmpctl_d;
      cmpa_sh_q  <= cmpa_sh_d;
      cmpa_act_q <= cmpa_act_d;
      cmpb_sh_q  <= cmpb_sh_d;
      cmpb_act_q <= cmpb_act_d;
      aqa_q      <= aqa_d;
      aqb_q      <= aqb_d;
      frc_q      <= frc_d;
      lvl_a_q    <= lvl_a_d;
      lvl_b_q    <= lvl_b_d;
    end
  end

`ifndef SYNTHESIS
  // A tick in a frozen mode leaves the counter alone.
  a_frozen_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cmd == tcpwm_pkg::CMD_TICK && tbctl_q[1:0] != tcpwm_pkg::MODE_UP)
    |=> $stable(cnt_q))
    else $error("counter moved in a frozen mode");

  // With a zero period every counting tick leaves the counter at zero.
  a_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && counting && prd_q == '0) |=> (cnt_q == '0))
    else $error("counter left zero with a zero period");

  // A counting tick from below the period advances by exactly one.
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && counting && cnt_q < prd_q)
    |=> (cnt_q == $past(cnt_q) + tcpwm_pkg::CountBits'(1)))
    else $error("counter did not advance by one");
`endif

endmodule

// ===== hdl/two_channel_pwm_timebase_unit.sv =====
// Top level of the two-channel PWM time base with shadowed compares.
// This unit is a PWM peripheral with one up-counting time base and two outputs, A and B.
// Every input word is a tick of the already prescaled time-base clock, a 16-bit register
// write or a 16-bit register read, and every word produces exactly one result word that
// carries the read data (zero unless the word was a read) and the levels of both outputs
// after the word took effect. A word is registered at the input, then processed
// combinationally against the register file, and its result is held in an output
// register; the unit accepts one word every clock cycle while the output side is not
// stalled. The combinational update of the counter, the compares and the action
// qualifiers sets that rate. The input stage keeps taking words while a result waits,
// until both stages are full.
module two_channel_pwm_timebase_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  reg_addr_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic        out_a_o,
  output logic        out_b_o
);

  // Input stage.
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_cmd_q;
  logic [4:0]  s1_addr_q;
  logic [15:0] s1_data_q;

  // Result stage.
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_rd_q;
  logic        out_a_q, out_b_q;

  logic        step;
  logic        out_free;
  logic [15:0] rd_d;
  logic        lvl_a_d, lvl_b_d;

  // The held word moves into the result register whenever that register is free.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  assign s1_valid_d  = (in_valid_i && in_ready_o) || (s1_valid_q && !out_free);
  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  tcpwm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .command_i    (s1_cmd_q),
    .reg_addr_i   (s1_addr_q),
    .write_data_i (s1_data_q),
    .read_data_o  (rd_d),
    .out_a_o      (lvl_a_d),
    .out_b_o      (lvl_b_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q  <= command_i;
      s1_addr_q <= reg_addr_i;
      s1_data_q <= write_data_i;
    end
    if (step) begin
      out_rd_q <= rd_d;
      out_a_q  <= lvl_a_d;
      out_b_q  <= lvl_b_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rd_q;
  assign out_a_o     = out_a_q;
  assign out_b_o     = out_b_q;

`ifndef SYNTHESIS
  // A word that leaves the input stage always lands in the result register.
  a_step_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed word did not reach the result register");

  // An empty input stage never refuses a word.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input refused while the input stage was empty");

  // With both stages full and the output stalled, nothing new is accepted.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("word accepted while both stages were full");
`endif

endmodule
